### src/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants and functions for great_circle_distance
// Fixed-point formats, CORDIC arctangent table and pipeline widths.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // port widths
    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int DIST_W = 25;

    // parameter defaults
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF   = 24;

    // internal widths
    localparam int WIDE_W  = 40;   // angle arithmetic before reduction
    localparam int TW      = 26;   // reduced angle, degrees
    localparam int DEG_W   = 31;   // pi/180 in Q36
    localparam int PW      = TW + DEG_W;
    localparam int CW      = 34;   // CORDIC x, y, z (Q30 signed)
    localparam int Q_W     = 31;   // Q30 value in [0, 1]
    localparam int OM_W    = 32;   // Q30 value in [0, 2]
    localparam int SQ_W    = 62;   // square root remainder and root
    localparam int SQRT_STEPS = 31;
    localparam int DP_W    = 55;   // angle times diameter

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_Q36_W = ((PI_Q60 / 180) + (64'd1 << 23)) >> 24;
    localparam logic [DEG_W-1:0] DEG_Q36 = DEG_Q36_W[DEG_W-1:0];
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [Q_W-1:0] ONE_Q30 = 31'd1073741824;
    localparam logic [23:0] DIAMETER_M = 24'd12742000;
    localparam logic [DIST_W:0] MAX_DIST = 26'd20015087;

    // atan(2^-idx) in Q30, from the alternating series in Q62
    function automatic logic [CW-1:0] atan_q30(input int idx);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] res;
        int d;
        sum = 64'd0;
        if (idx == 0) begin
            res = (PI_Q60 + (64'd1 << 31)) >> 32;
        end else begin
            for (int k = 0; k < 32; k++) begin
                d = 2 * k + 1;
                if (idx * d <= 62) begin
                    term = (64'd1 << (62 - idx * d)) / 64'(d);
                    if (k % 2 == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            res = (sum + (64'd1 << 31)) >> 32;
        end
        return res[CW-1:0];
    endfunction

    // symmetric clamp to [-lim, lim]
    function automatic logic signed [WIDE_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [WIDE_W-1:0] lim
    );
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

### src/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance: haversine distance between two lat/lon points
// Fully pipelined fixed-point datapath: rotation CORDIC cosines, products,
// digit-by-digit square roots and a vectoring CORDIC arctangent.
// ----------------------------------------------------------------------------
// One pair of points enters per clock and one distance in metres leaves per
// clock unless the result side stalls. The two CORDIC chains take one
// iteration per stage and the square roots one result bit per stage. Angles
// carry ANGLE_FRAC_BITS fraction bits of a degree and saturate at +-90
// (latitude) and +-180 (longitude). A stall on the result side holds every
// stage; nothing is dropped or repeated.
module great_circle_distance #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gcd_pkg::LAT_W-1:0]    s_lat_a,
    input  logic signed [gcd_pkg::LON_W-1:0]    s_lon_a,
    input  logic signed [gcd_pkg::LAT_W-1:0]    s_lat_b,
    input  logic signed [gcd_pkg::LON_W-1:0]    s_lon_b,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gcd_pkg::DIST_W-1:0]          m_distance_m
);
    import gcd_pkg::*;

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int N   = CORDIC_STAGES;
    localparam int SQ  = SQRT_STEPS;
    localparam int LAT = 12 + 2 * N + SQ;

    localparam logic signed [WIDE_W-1:0] DEG90  = WIDE_W'(90) <<< F;
    localparam logic signed [WIDE_W-1:0] DEG180 = WIDE_W'(180) <<< F;
    localparam logic signed [WIDE_W-1:0] DEG360 = WIDE_W'(360) <<< F;
    localparam logic [PW:0] ZRND = (PW + 1)'(1) << (F + 5);

    // pipeline advance
    logic ce;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;
    assign m_valid = valid_reg[LAT-1];
    assign valid_next = {valid_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    // stage A: saturate inputs
    logic signed [LAT_W-1:0] la_reg, lb_reg, la_next, lb_next;
    logic signed [LON_W-1:0] oa_reg, ob_reg, oa_next, ob_next;
    logic signed [WIDE_W-1:0] la_c, lb_c, oa_c, ob_c;

    always_comb begin
        la_c = clamp_sym(WIDE_W'(s_lat_a), DEG90);
        lb_c = clamp_sym(WIDE_W'(s_lat_b), DEG90);
        oa_c = clamp_sym(WIDE_W'(s_lon_a), DEG180);
        ob_c = clamp_sym(WIDE_W'(s_lon_b), DEG180);
        la_next = la_c[LAT_W-1:0];
        lb_next = lb_c[LAT_W-1:0];
        oa_next = oa_c[LON_W-1:0];
        ob_next = ob_c[LON_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            la_reg <= la_next;
            lb_reg <= lb_next;
            oa_reg <= oa_next;
            ob_reg <= ob_next;
        end
    end

    // stage B: angle magnitudes, longitude wrap, fold into [0, 90]
    // lanes: 0 dlat, 1 dlon, 2 lat_a, 3 lat_b
    logic [TW-1:0] t_reg [4];
    logic [TW-1:0] t_next [4];
    logic [3:0] neg_reg, neg_next;
    logic signed [WIDE_W-1:0] ang [4];
    logic signed [WIDE_W-1:0] dv, fv;

    always_comb begin
        dv = WIDE_W'(lb_reg) - WIDE_W'(la_reg);
        ang[0] = (dv < 0) ? -dv : dv;
        dv = WIDE_W'(ob_reg) - WIDE_W'(oa_reg);
        ang[1] = (dv < 0) ? -dv : dv;
        if (ang[1] > DEG180) begin
            ang[1] = DEG360 - ang[1];
        end
        ang[2] = (la_reg < 0) ? -WIDE_W'(la_reg) : WIDE_W'(la_reg);
        ang[3] = (lb_reg < 0) ? -WIDE_W'(lb_reg) : WIDE_W'(lb_reg);
        for (int l = 0; l < 4; l++) begin
            fv = ang[l];
            neg_next[l] = 1'b0;
            if (fv > DEG90) begin
                neg_next[l] = 1'b1;
                fv = DEG180 - fv;
            end
            t_next[l] = fv[TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t_reg   <= t_next;
            neg_reg <= neg_next;
        end
    end

    // stage C: degrees to radians
    logic [PW-1:0] zp_reg [4];
    logic [1:0] zp_neg_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < 4; l++) begin
                zp_reg[l] <= PW'(t_reg[l]) * PW'(DEG_Q36);
            end
            zp_neg_reg <= neg_reg[1:0];
        end
    end

    // stage D: round to Q30 and seed the rotation CORDIC
    logic signed [CW-1:0] rot_x_reg [0:N][4];
    logic signed [CW-1:0] rot_y_reg [0:N][4];
    logic signed [CW-1:0] rot_z_reg [0:N][4];
    logic [1:0] rot_neg_reg [0:N];
    logic [PW:0] zr [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            zr[l] = ((PW + 1)'(zp_reg[l]) + ZRND) >> (F + 6);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < 4; l++) begin
                rot_x_reg[0][l] <= GAIN_Q30;
                rot_y_reg[0][l] <= '0;
                rot_z_reg[0][l] <= zr[l][CW-1:0];
            end
            rot_neg_reg[0] <= zp_neg_reg;
        end
    end

    // rotation CORDIC, one iteration per stage
    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [CW-1:0] ATAN_I = atan_q30(i);
        logic signed [CW-1:0] x_next [4];
        logic signed [CW-1:0] y_next [4];
        logic signed [CW-1:0] z_next [4];

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                if (rot_z_reg[i][l] >= 0) begin
                    x_next[l] = rot_x_reg[i][l] - (rot_y_reg[i][l] >>> i);
                    y_next[l] = rot_y_reg[i][l] + (rot_x_reg[i][l] >>> i);
                    z_next[l] = rot_z_reg[i][l] - ATAN_I;
                end else begin
                    x_next[l] = rot_x_reg[i][l] + (rot_y_reg[i][l] >>> i);
                    y_next[l] = rot_y_reg[i][l] - (rot_x_reg[i][l] >>> i);
                    z_next[l] = rot_z_reg[i][l] + ATAN_I;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rot_x_reg[i+1]   <= x_next;
                rot_y_reg[i+1]   <= y_next;
                rot_z_reg[i+1]   <= z_next;
                rot_neg_reg[i+1] <= rot_neg_reg[i];
            end
        end
    end

    // stage E: clamp cosines; 1 - cos for the differences
    logic [OM_W-1:0] om_lat_reg, om_lon_reg, om_lat_next, om_lon_next;
    logic [Q_W-1:0] c1_reg, c2_reg, c1_next, c2_next;
    logic [Q_W-1:0] xc [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (rot_x_reg[N][l] < 0) begin
                xc[l] = '0;
            end else if (rot_x_reg[N][l] > CW'(ONE_Q30)) begin
                xc[l] = ONE_Q30;
            end else begin
                xc[l] = rot_x_reg[N][l][Q_W-1:0];
            end
        end
        om_lat_next = rot_neg_reg[N][0] ? OM_W'(ONE_Q30) + OM_W'(xc[0])
                                        : OM_W'(ONE_Q30) - OM_W'(xc[0]);
        om_lon_next = rot_neg_reg[N][1] ? OM_W'(ONE_Q30) + OM_W'(xc[1])
                                        : OM_W'(ONE_Q30) - OM_W'(xc[1]);
        c1_next = xc[2];
        c2_next = xc[3];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            om_lat_reg <= om_lat_next;
            om_lon_reg <= om_lon_next;
            c1_reg     <= c1_next;
            c2_reg     <= c2_next;
        end
    end

    // stage F: cos(lat_a) * cos(lat_b)
    logic [2*Q_W-1:0] pp_reg;
    logic [OM_W-1:0] f_om_lat_reg, f_om_lon_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            pp_reg       <= (2*Q_W)'(c1_reg) * (2*Q_W)'(c2_reg);
            f_om_lat_reg <= om_lat_reg;
            f_om_lon_reg <= om_lon_reg;
        end
    end

    // stage G: round product to Q30
    logic [Q_W-1:0] p_reg;
    logic [OM_W-1:0] g_om_lat_reg, g_om_lon_reg;
    logic [2*Q_W:0] pr;

    assign pr = ((2*Q_W + 1)'(pp_reg) + ((2*Q_W + 1)'(1) << 29)) >> 30;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg        <= pr[Q_W-1:0];
            g_om_lat_reg <= f_om_lat_reg;
            g_om_lon_reg <= f_om_lon_reg;
        end
    end

    // stage H: p * (1 - cos dlon)
    logic [Q_W+OM_W-1:0] pm_reg;
    logic [OM_W-1:0] h_om_lat_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            pm_reg       <= (Q_W+OM_W)'(p_reg) * (Q_W+OM_W)'(g_om_lon_reg);
            h_om_lat_reg <= g_om_lat_reg;
        end
    end

    // stage I: haversine a, clamp, seed both square roots
    logic [SQ_W-1:0] sq_v_reg [0:SQ][2];
    logic [SQ_W-1:0] sq_r_reg [0:SQ][2];
    logic [63:0] hsum;
    logic [63:0] aw;
    logic [Q_W-1:0] a_val;

    always_comb begin
        hsum = {h_om_lat_reg, 30'd0} + 64'(pm_reg);
        aw   = (hsum + (64'd1 << 30)) >> 31;
        a_val = (aw > 64'(ONE_Q30)) ? ONE_Q30 : aw[Q_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_v_reg[0][0] <= SQ_W'(a_val) << 30;
            sq_v_reg[0][1] <= SQ_W'(ONE_Q30 - a_val) << 30;
            sq_r_reg[0][0] <= '0;
            sq_r_reg[0][1] <= '0;
        end
    end

    // digit-by-digit square root, one result bit per stage
    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT_J = SQ_W'(1) << (60 - 2 * j);
        logic [SQ_W-1:0] v_next [2];
        logic [SQ_W-1:0] r_next [2];
        logic [SQ_W-1:0] trial [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                trial[l] = sq_r_reg[j][l] + BIT_J;
                if (sq_v_reg[j][l] >= trial[l]) begin
                    v_next[l] = sq_v_reg[j][l] - trial[l];
                    r_next[l] = (sq_r_reg[j][l] >> 1) + BIT_J;
                end else begin
                    v_next[l] = sq_v_reg[j][l];
                    r_next[l] = sq_r_reg[j][l] >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_v_reg[j+1] <= v_next;
                sq_r_reg[j+1] <= r_next;
            end
        end
    end

    // stage J: round roots, seed vectoring CORDIC (y = sqrt a, x = sqrt 1-a)
    logic signed [CW-1:0] vec_x_reg [0:N];
    logic signed [CW-1:0] vec_y_reg [0:N];
    logic signed [CW-1:0] vec_z_reg [0:N];
    logic [SQ_W-1:0] root [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            root[l] = sq_r_reg[SQ][l] + SQ_W'(sq_v_reg[SQ][l] > sq_r_reg[SQ][l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            vec_y_reg[0] <= root[0][CW-1:0];
            vec_x_reg[0] <= root[1][CW-1:0];
            vec_z_reg[0] <= '0;
        end
    end

    // vectoring CORDIC, one iteration per stage
    for (genvar i = 0; i < N; i++) begin : g_vec
        localparam logic signed [CW-1:0] ATAN_I = atan_q30(i);
        logic signed [CW-1:0] x_next, y_next, z_next;

        always_comb begin
            if (vec_y_reg[i] >= 0) begin
                x_next = vec_x_reg[i] + (vec_y_reg[i] >>> i);
                y_next = vec_y_reg[i] - (vec_x_reg[i] >>> i);
                z_next = vec_z_reg[i] + ATAN_I;
            end else begin
                x_next = vec_x_reg[i] - (vec_y_reg[i] >>> i);
                y_next = vec_y_reg[i] + (vec_x_reg[i] >>> i);
                z_next = vec_z_reg[i] - ATAN_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                vec_x_reg[i+1] <= x_next;
                vec_y_reg[i+1] <= y_next;
                vec_z_reg[i+1] <= z_next;
            end
        end
    end

    // stage K: clamp angle at zero, scale by diameter
    logic [DP_W-1:0] dp_reg;
    logic [Q_W-1:0] zc;

    assign zc = (vec_z_reg[N] < 0) ? '0 : vec_z_reg[N][Q_W-1:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dp_reg <= DP_W'(zc) * DP_W'(DIAMETER_M);
        end
    end

    // stage L: round to metres, output word
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [DP_W:0] dr;

    always_comb begin
        dr = ((DP_W + 1)'(dp_reg) + ((DP_W + 1)'(1) << 29)) >> 30;
        dist_next = (dr > (DP_W + 1)'(MAX_DIST)) ? MAX_DIST[DIST_W-1:0]
                                                 : dr[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dist_reg <= dist_next;
        end
    end

    assign m_distance_m = dist_reg;

    // checks
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted word did not enter pipeline");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_distance_m <= MAX_DIST[DIST_W-1:0]))
        else $error("distance out of range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> (valid_reg == $past(valid_reg)))
        else $error("pipeline moved during stall");

endmodule

### sim/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker: scoreboard for great_circle_distance
// Watches both channels, predicts each distance with an independent
// fixed-point haversine model and compares it with the returned word.
// ----------------------------------------------------------------------------
module gcd_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [gcd_pkg::LAT_W-1:0]  s_lat_a,
    input  logic signed [gcd_pkg::LON_W-1:0]  s_lon_a,
    input  logic signed [gcd_pkg::LAT_W-1:0]  s_lat_b,
    input  logic signed [gcd_pkg::LON_W-1:0]  s_lon_b,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [gcd_pkg::DIST_W-1:0]        m_distance_m,
    output int                                fail_count,
    output int                                pending
);
    localparam int FRAC   = 16;
    localparam int STAGES = 24;
    localparam longint ONE = 64'sd1 << 30;

    logic [gcd_pkg::DIST_W-1:0] dist_fifo[$];
    longint arctan_q30[32];

    // arctangent table, Q62 series rounded to Q30
    initial begin
        longint unsigned acc;
        longint unsigned part;
        arctan_q30[0] = longint'((64'h3243F6A8885A308D + (64'd1 << 31)) >> 32);
        for (int i = 1; i < 32; i++) begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                part = (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
                if (k % 2 == 1) begin
                    acc = acc - part;
                end else begin
                    acc = acc + part;
                end
            end
            arctan_q30[i] = longint'((acc + (64'd1 << 31)) >> 32);
        end
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    // cosine of t degrees, t in [0, 180], Q30
    function automatic longint cosine_deg(longint t);
        longint unsigned deg_q36;
        longint x, y, z, nx;
        bit flip;
        deg_q36 = ((64'h3243F6A8885A308D / 180) + (64'd1 << 23)) >> 24;
        flip = 0;
        if (t > (180 << FRAC)) t = 180 << FRAC;
        if (t > (90 << FRAC)) begin
            flip = 1;
            t = (180 << FRAC) - t;
        end
        z = longint'((longint'(t) * deg_q36 + (64'd1 << (FRAC + 5))) >> (FRAC + 6));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_q30[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_q30[i];
            end
            x = nx;
        end
        x = clip(x, 0, ONE);
        return flip ? -x : x;
    endfunction

    // integer square root, rounded to nearest
    function automatic longint unsigned root_nearest(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    function automatic logic [gcd_pkg::DIST_W-1:0] haversine_m(
        longint lat1, longint lon1, longint lat2, longint lon2);
        longint la, oa, lb, ob, cdl, cdo, c1, c2, x, y, z, nx;
        longint unsigned dl, dlon, prod, total, hav, meters;
        la = clip(lat1, -(90 << FRAC), 90 << FRAC);
        oa = clip(lon1, -(180 << FRAC), 180 << FRAC);
        lb = clip(lat2, -(90 << FRAC), 90 << FRAC);
        ob = clip(lon2, -(180 << FRAC), 180 << FRAC);
        dl = absval(lb - la);
        dlon = absval(ob - oa);
        if (dlon > (180 << FRAC)) dlon = (360 << FRAC) - dlon;
        cdl = cosine_deg(dl);
        cdo = cosine_deg(dlon);
        c1 = clip(cosine_deg(absval(la)), 0, ONE);
        c2 = clip(cosine_deg(absval(lb)), 0, ONE);
        prod = (longint'(c1) * longint'(c2) + (64'd1 << 29)) >> 30;
        total = (longint'(ONE - cdl) << 30) + prod * longint'(ONE - cdo);
        hav = (total + (64'd1 << 30)) >> 31;
        if (hav > ONE) hav = ONE;
        y = root_nearest(hav << 30);
        x = root_nearest((ONE - hav) << 30);
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_q30[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_q30[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        meters = (longint'(z) * 12742000 + (64'd1 << 29)) >> 30;
        if (meters > 20015087) meters = 20015087;
        return meters[gcd_pkg::DIST_W-1:0];
    endfunction

    // predict on input words, compare on result words
    always @(posedge aclk) begin
        logic [gcd_pkg::DIST_W-1:0] want;
        if (!aresetn) begin
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) begin
                dist_fifo.push_back(haversine_m(s_lat_a, s_lon_a, s_lat_b, s_lon_b));
            end
            if (m_valid && m_ready) begin
                if (dist_fifo.size() == 0) begin
                    $display("%0t: unexpected word, got %0d", $realtime, m_distance_m);
                    fail_count <= fail_count + 1;
                end else begin
                    want = dist_fifo.pop_front();
                    if (want !== m_distance_m) begin
                        $display("%0t: distance_m expected %0d got %0d",
                                 $realtime, want, m_distance_m);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= dist_fifo.size();
        end
    end
endmodule

### sim/tb_great_circle_distance.sv
// ----------------------------------------------------------------------------
// tb_great_circle_distance: testbench for great_circle_distance
// Directed corner pairs then random point pairs with bursty input and
// stalling output; the checker predicts and compares every distance.
// ----------------------------------------------------------------------------
module tb_great_circle_distance;
    import gcd_pkg::*;

    localparam int LAT_MAX = 90 << 16;
    localparam int LON_MAX = 180 << 16;
    localparam int RAND_WORDS = 900;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [LAT_W-1:0] s_lat_a = 0;
    logic signed [LON_W-1:0] s_lon_a = 0;
    logic signed [LAT_W-1:0] s_lat_b = 0;
    logic signed [LON_W-1:0] s_lon_b = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [DIST_W-1:0] m_distance_m;
    int fail_count;
    int pending;
    int cycles = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    great_circle_distance dut (.*);
    gcd_checker u_checker (.*);

    // timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("great_circle_distance: mismatch");
            $finish;
        end
    end

    // receiver stall pattern: calm stretches and busy stretches
    always @(posedge aclk) begin
        if ((cycles / 500) % 3 == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // drop valid between words for a gap of length n
    task automatic idle(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // one word, held until accepted, with a gap beforehand when asked
    task automatic send_pair(int la, int oa, int lb, int ob, int gap);
        idle(gap);
        s_valid <= 1'b1;
        s_lat_a <= LAT_W'(la);
        s_lon_a <= LON_W'(oa);
        s_lat_b <= LAT_W'(lb);
        s_lon_b <= LON_W'(ob);
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic int rand_lat();
        case ($urandom_range(0, 9))
            0: return $signed($urandom()) >>> 8;   // any 24-bit value, may saturate
            1: return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
            default: return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
        endcase
    endfunction

    function automatic int rand_lon();
        case ($urandom_range(0, 9))
            0: return $signed($urandom()) >>> 7;   // any 25-bit value
            1: return $urandom_range(0, 1) ? LON_MAX : -LON_MAX;
            default: return int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
        endcase
    endfunction

    initial begin
        int burst;
        int la, oa;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: same point, poles, antipodes, dateline wrap, saturation
        send_pair(0, 0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);
        send_pair(0, 0, 0, LON_MAX, 0);
        send_pair(0, -LON_MAX, 0, LON_MAX, 0);
        send_pair(0, LON_MAX - 65536, 0, -LON_MAX + 65536, 0);
        send_pair(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000, 0);
        send_pair(24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF, 1);
        send_pair(-1, -1, 1, 1, 0);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, 0);
        send_pair(45 << 16, 90 << 16, -45 << 16, -90 << 16, 0);
        send_pair(0, 0, 1, 0, 0);
        send_pair(60 << 16, 10 << 16, 60 << 16, 100 << 16, 2);
        send_pair(-LAT_MAX, 5, -LAT_MAX + 1, -7, 0);
        send_pair(LAT_MAX, 0, 0, 0, 0);
        send_pair(0, 91 << 16, 0, -91 << 16, 0);

        // random bursts; some near-neighbor pairs for short distances
        for (int n = 0; n < RAND_WORDS; ) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && n < RAND_WORDS; j++, n++) begin
                la = rand_lat();
                oa = rand_lon();
                if ($urandom_range(0, 4) == 0) begin
                    send_pair(la, oa, la + int'($urandom_range(0, 2000)) - 1000,
                              oa + int'($urandom_range(0, 2000)) - 1000, 0);
                end else begin
                    send_pair(la, oa, rand_lat(), rand_lon(), 0);
                end
            end
            idle(int'($urandom_range(0, 6)));
        end
        s_valid <= 1'b0;

        // drain, then allow for pipeline latency
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (fail_count == 0) begin
            $display("great_circle_distance: match");
        end else begin
            $display("great_circle_distance: mismatch");
        end
        $finish;
    end
endmodule
